// ===== hw/rtl/v210bb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// V210 bit-bar burner package
// Shared constants, register codes and transaction types for the bit-bar
// burner and its sub-modules.
// ----------------------------------------------------------------------------
package v210bb_pkg;

  // Raster limits; the position counters saturate one below these.
  localparam int MAX_LINE_WORDS = 4096;
  localparam int MAX_LINES      = 4096;
  localparam int COL_W          = $clog2(MAX_LINE_WORDS);
  localparam int LINE_W         = $clog2(MAX_LINES);

  localparam logic [COL_W-1:0]  COL_MAX  = COL_W'(MAX_LINE_WORDS - 1);
  localparam logic [LINE_W-1:0] LINE_MAX = LINE_W'(MAX_LINES - 1);

  // Field widths.
  localparam int WORD_W        = 32;
  localparam int STAMP_LINE_W  = 12;
  localparam int CFG_IDX_W     = 2;
  localparam int LINE_CMP_W    = ((LINE_W > STAMP_LINE_W) ? LINE_W : STAMP_LINE_W) + 1;

  // Box geometry: 4 words carry 6 pixels, and 32 boxes form the bar.
  localparam int BOX_COUNT       = 32;
  localparam int BOX_IDX_W       = $clog2(BOX_COUNT);
  localparam int BOX_PIX_SMALL   = 18;
  localparam int BOX_PIX_LARGE   = 30;
  localparam int BOX_WORDS_SMALL = (BOX_PIX_SMALL / 6) * 4;
  localparam int BOX_WORDS_LARGE = (BOX_PIX_LARGE / 6) * 4;
  localparam int BOX_PIX_W       = 5;

  // V210 component levels.
  localparam logic [9:0] LUMA_WHITE = 10'h3ff;
  localparam logic [9:0] LUMA_BLACK = 10'h000;
  localparam logic [9:0] CHROMA_MID = 10'h200;

  // Four-word groups that repeat across a box, indexed by column modulo 4.
  // Entries are listed from index 3 down to index 0.
  localparam logic [3:0][WORD_W-1:0] WHITE_GROUP = {
    {2'b00, LUMA_WHITE, CHROMA_MID, LUMA_WHITE},
    {2'b00, CHROMA_MID, LUMA_WHITE, CHROMA_MID},
    {2'b00, LUMA_WHITE, CHROMA_MID, LUMA_WHITE},
    {2'b00, CHROMA_MID, LUMA_WHITE, CHROMA_MID}
  };
  localparam logic [3:0][WORD_W-1:0] BLACK_GROUP = {
    {2'b00, LUMA_BLACK, CHROMA_MID, LUMA_BLACK},
    {2'b00, CHROMA_MID, LUMA_BLACK, CHROMA_MID},
    {2'b00, LUMA_BLACK, CHROMA_MID, LUMA_BLACK},
    {2'b00, CHROMA_MID, LUMA_BLACK, CHROMA_MID}
  };

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STAMP_VALUE = 2'd0,
    CFG_STAMP_LINE  = 2'd1,
    CFG_LARGE_BOXES = 2'd2
  } cfg_index_t;

  typedef struct packed {
    logic [WORD_W-1:0]       stamp_value;
    logic [STAMP_LINE_W-1:0] stamp_line;
    logic                    large_boxes;
  } cfg_t;

  // Raster position of the word being accepted.
  typedef struct packed {
    logic [LINE_W-1:0] line;
    logic [COL_W-1:0]  col;
  } pos_t;

  // One result transaction.
  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              frame_start;
    logic              line_end;
    logic              in_stamp;
  } item_t;

endpackage

// ===== hw/rtl/v210bb_pos_track.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Raster position tracker
// Keeps the line and word column of the next word and presents the position
// of the word currently offered, restarting at the frame start mark.
// ----------------------------------------------------------------------------
module v210bb_pos_track
  import v210bb_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic take,
  input  logic frame_start,
  input  logic line_end,
  output pos_t pos
);

  logic [LINE_W-1:0] line_r, line_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;

  // A frame start places this word at the top-left corner.
  always_comb begin
    pos.line = frame_start ? '0 : line_r;
    pos.col  = frame_start ? '0 : col_r;
  end

  // Advance after the word; both counters saturate.
  always_comb begin
    line_nxt = line_r;
    col_nxt  = col_r;
    if (take) begin
      if (line_end) begin
        line_nxt = (pos.line != LINE_MAX) ? pos.line + 1'b1 : pos.line;
        col_nxt  = '0;
      end else begin
        line_nxt = pos.line;
        col_nxt  = (pos.col != COL_MAX) ? pos.col + 1'b1 : pos.col;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_r <= '0;
      col_r  <= '0;
    end else begin
      line_r <= line_nxt;
      col_r  <= col_nxt;
    end
  end

  // The word after a line end always opens at column zero.
  a_col_restart: assert property (@(posedge clk) disable iff (!rst_n)
    take && line_end |=> col_r == '0)
    else $error("column did not restart after line end");

  // A word carrying both marks is line 0, so the next one is line 1.
  a_single_word_line: assert property (@(posedge clk) disable iff (!rst_n)
    take && frame_start && line_end |=> line_r == LINE_W'(1))
    else $error("line count wrong after single-word line");

  // Without an accepted word the position holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !take |=> $stable(line_r) && $stable(col_r))
    else $error("position moved without a transaction");

endmodule

// ===== hw/rtl/v210bb_stamp_gen.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Box stamp generator
// Decides whether a word lies inside the bar of boxes and, if so, replaces it
// with the white or black group word for the box's bit of the stamp value.
// ----------------------------------------------------------------------------
module v210bb_stamp_gen
  import v210bb_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  cfg_t              cfg,
  input  pos_t              pos,
  input  logic [WORD_W-1:0] pixel_word,
  input  logic              frame_start,
  input  logic              line_end,
  output item_t             item
);

  logic [BOX_PIX_W-1:0]  box_pix;
  logic [LINE_CMP_W-1:0] line_ext, start_ext, line_diff;
  logic                  in_rows, in_cols, stamp, bit_sel;
  logic [COL_W-1:0]      col_limit;
  logic [7:0]            quad;
  logic [15:0]           prod3;
  logic [17:0]           prod5;
  logic [BOX_IDX_W-1:0]  box;

  // Row test: stamp_line <= line < stamp_line + box height.
  always_comb begin
    box_pix   = cfg.large_boxes ? BOX_PIX_W'(BOX_PIX_LARGE) : BOX_PIX_W'(BOX_PIX_SMALL);
    line_ext  = LINE_CMP_W'(pos.line);
    start_ext = LINE_CMP_W'(cfg.stamp_line);
    line_diff = line_ext - start_ext;
    in_rows   = (line_ext >= start_ext) && (line_diff < LINE_CMP_W'(box_pix));
  end

  // Column test against the width of all 32 boxes.
  always_comb begin
    col_limit = cfg.large_boxes ? COL_W'(BOX_COUNT * BOX_WORDS_LARGE)
                                : COL_W'(BOX_COUNT * BOX_WORDS_SMALL);
    in_cols   = pos.col < col_limit;
  end

  // Box index: the column in 4-word groups divided by 3 or 5, done by
  // reciprocal multiplication, exact over the column range of the bar.
  always_comb begin
    quad  = pos.col[9:2];
    prod3 = 16'(quad) * 16'd171;
    prod5 = 18'(quad) * 18'd205;
    box   = cfg.large_boxes ? prod5[14:10] : prod3[13:9];
  end

  // Leftmost box carries the most significant bit.
  always_comb begin
    bit_sel          = cfg.stamp_value[BOX_IDX_W'(BOX_COUNT - 1) - box];
    stamp            = in_rows && in_cols;
    item.frame_start = frame_start;
    item.line_end    = line_end;
    item.in_stamp    = stamp;
    if (!stamp) begin
      item.word = pixel_word;
    end else if (bit_sel) begin
      item.word = WHITE_GROUP[pos.col[1:0]];
    end else begin
      item.word = BLACK_GROUP[pos.col[1:0]];
    end
  end

  // A stamped word always lies within the bar's columns.
  a_stamp_cols: assert property (@(posedge clk) disable iff (!rst_n)
    item.in_stamp |-> pos.col < col_limit)
    else $error("stamp outside the bar columns");

  // A stamped word is one of the two group words for its column.
  a_stamp_word: assert property (@(posedge clk) disable iff (!rst_n)
    item.in_stamp |-> (item.word == WHITE_GROUP[pos.col[1:0]]) ||
                      (item.word == BLACK_GROUP[pos.col[1:0]]))
    else $error("stamped word is not a box pattern");

  // Outside the bar the word passes through untouched.
  a_pass: assert property (@(posedge clk) disable iff (!rst_n)
    !item.in_stamp |-> item.word == pixel_word)
    else $error("word altered outside the bar");

endmodule

// ===== hw/rtl/v210bb_out_skid.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Output register with skid stage
// Holds the result transaction for the receiver and parks one more behind it,
// so that the input stall is driven from a register.
// ----------------------------------------------------------------------------
module v210bb_out_skid
  import v210bb_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_stall,
  input  item_t in_item,
  output logic  out_valid,
  input  logic  out_stall,
  output item_t out_item
);

  logic  out_valid_r, out_valid_nxt;
  logic  skid_valid_r, skid_valid_nxt;
  item_t out_item_r, out_item_nxt;
  item_t skid_item_r, skid_item_nxt;
  logic  in_take, out_take;

  assign in_stall  = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
  assign in_take   = in_valid && !skid_valid_r;
  assign out_take  = out_valid_r && !out_stall;

  // Refill the output from the skid stage first, then from the input.
  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_item_nxt   = out_item_r;
    skid_item_nxt  = skid_item_r;
    if (skid_valid_r) begin
      if (out_take) begin
        out_item_nxt   = skid_item_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (in_take) begin
      if (!out_valid_r || out_take) begin
        out_item_nxt  = in_item;
        out_valid_nxt = 1'b1;
      end else begin
        skid_item_nxt  = in_item;
        skid_valid_nxt = 1'b1;
      end
    end else if (out_take) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r  <= out_item_nxt;
    skid_item_r <= skid_item_nxt;
  end

  // The skid stage is only occupied behind a held output.
  a_skid_behind: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid stage full with output empty");

  // A transaction arriving while the output is held lands in the skid stage.
  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    in_take && out_valid_r && out_stall |=> skid_valid_r)
    else $error("transaction lost behind a stalled output");

  // When the receiver takes the output and a skid entry waits, output stays valid.
  a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r && out_take |=> out_valid_r && !skid_valid_r)
    else $error("skid entry not moved to output");

endmodule

// ===== hw/rtl/v210_bit_bar_burner.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// V210 bit-bar burner
// Burns a row of 32 black and white boxes, carrying a 32-bit value, into a
// V210 raster stream; all other words pass through unchanged.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one V210 word per transaction
//   with frame start and line end marks. Output channel (out_valid /
//   out_stall) returns exactly one word per input transaction, in order, with
//   both marks copied and out_in_stamp set when the word was replaced.
//   Configuration (cfg_valid / cfg_ready, always ready) writes stamp value,
//   stamp line and box size by index; write only while the stream is idle.
//   An accepted word is registered in the output register. Throughput is
//   one word per cycle while the receiver does not stall: the position and
//   box decode are combinational ahead of the output register.
//   When the receiver stalls, one further transaction is parked in a skid
//   stage and in_stall rises in the following cycle; in_stall is driven
//   straight from that stage's register.
//   Reset clears the line and column counters, the configuration registers
//   and both output stages. A stream without a frame start mark counts on
//   from line 0, column 0.
// ----------------------------------------------------------------------------
module v210_bit_bar_burner
  import v210bb_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  // Configuration write channel
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [WORD_W-1:0]       cfg_data,
  // Input channel
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [WORD_W-1:0]       in_pixel_word,
  input  logic                    in_frame_start,
  input  logic                    in_line_end,
  // Output channel
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [WORD_W-1:0]       out_word,
  output logic                    out_frame_start,
  output logic                    out_line_end,
  output logic                    out_in_stamp
);

  cfg_t  cfg_r, cfg_nxt;
  pos_t  pos;
  item_t new_item, res_item;
  logic  in_take;

  assign cfg_ready = 1'b1;
  assign in_take   = in_valid && !in_stall;

  // Configuration register writes; unknown indexes are ignored.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_STAMP_VALUE: cfg_nxt.stamp_value = cfg_data;
        CFG_STAMP_LINE:  cfg_nxt.stamp_line  = cfg_data[STAMP_LINE_W-1:0];
        CFG_LARGE_BOXES: cfg_nxt.large_boxes = cfg_data[0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Raster position of the offered word.
  v210bb_pos_track u_pos_track (
    .clk         (clk),
    .rst_n       (rst_n),
    .take        (in_take),
    .frame_start (in_frame_start),
    .line_end    (in_line_end),
    .pos         (pos)
  );

  // Box decode and word replacement.
  v210bb_stamp_gen u_stamp_gen (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .pos         (pos),
    .pixel_word  (in_pixel_word),
    .frame_start (in_frame_start),
    .line_end    (in_line_end),
    .item        (new_item)
  );

  // Result register and skid stage.
  v210bb_out_skid u_out_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (new_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (res_item)
  );

  assign out_word        = res_item.word;
  assign out_frame_start = res_item.frame_start;
  assign out_line_end    = res_item.line_end;
  assign out_in_stamp    = res_item.in_stamp;

  // After an accepted transaction the output is always valid in the next cycle.
  a_out_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> out_valid)
    else $error("accepted transaction did not reach the output");

  // Input is only stalled while the output is also holding a transaction.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with nothing held");

  // A write to a known index changes only that register; checked for a stamp line write.
  a_cfg_line: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && (cfg_index == CFG_STAMP_LINE) |=> $stable(cfg_r.stamp_value))
    else $error("stamp value changed by a stamp line write");

endmodule
